// ----- design/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is high
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that is checked through reset as well
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/tksd_pkg.sv -----
package tksd_pkg;

  // line buffer geometry
  localparam int LINE_MAX = 32;
  localparam int ADDR_W   = $clog2(LINE_MAX);
  localparam int LEN_W    = 6;

  // payload widths
  localparam int REQ_W  = 2;
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 5;
  localparam int CMD_W  = 4;

  // request codes
  localparam logic [REQ_W-1:0] REQ_BYTE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // command codes
  localparam logic [CMD_W-1:0] ACT_NONE        = 4'd0;
  localparam logic [CMD_W-1:0] ACT_RIGHT       = 4'd1;
  localparam logic [CMD_W-1:0] ACT_LEFT        = 4'd2;
  localparam logic [CMD_W-1:0] ACT_UP          = 4'd3;
  localparam logic [CMD_W-1:0] ACT_DOWN        = 4'd4;
  localparam logic [CMD_W-1:0] ACT_SHIFT_LEFT  = 4'd5;
  localparam logic [CMD_W-1:0] ACT_CONFIRM     = 4'd6;
  localparam logic [CMD_W-1:0] ACT_SHIFT_RIGHT = 4'd7;
  localparam logic [CMD_W-1:0] ACT_LINE        = 4'd8;
  localparam logic [CMD_W-1:0] ACT_EXIT        = 4'd9;

  // special bytes
  localparam logic [BYTE_W-1:0] K_ESC     = 8'd27;
  localparam logic [BYTE_W-1:0] K_BRACKET = 8'd91;
  localparam logic [BYTE_W-1:0] K_DEL     = 8'd127;
  localparam logic [BYTE_W-1:0] K_BS      = 8'd8;
  localparam logic [BYTE_W-1:0] K_QUIT    = 8'd96;
  localparam logic [BYTE_W-1:0] K_TILDE   = 8'd126;
  localparam logic [BYTE_W-1:0] K_LF      = 8'd10;
  localparam logic [BYTE_W-1:0] K_CR      = 8'd13;
  localparam logic [BYTE_W-1:0] K_UP_A    = 8'd65;
  localparam logic [BYTE_W-1:0] K_DOWN_B  = 8'd66;
  localparam logic [BYTE_W-1:0] K_RIGHT_C = 8'd67;
  localparam logic [BYTE_W-1:0] K_LEFT_D  = 8'd68;
  localparam logic [BYTE_W-1:0] K_ONE     = 8'd49;
  localparam logic [BYTE_W-1:0] K_TWO     = 8'd50;
  localparam logic [BYTE_W-1:0] K_FIVE    = 8'd53;

  typedef enum logic [1:0] {
    PS_IDLE,
    PS_ESC,
    PS_BRACKET,
    PS_TILDE
  } parse_state_t;

endpackage

// ----- design/tksd_if.sv -----
interface tksd_item_if import tksd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [BYTE_W-1:0] rx_byte;
  logic [IDX_W-1:0]  read_index;

  modport source (output valid, output req_type, output rx_byte, output read_index,
                  input ready);
  modport sink   (input valid, input req_type, input rx_byte, input read_index,
                  output ready);
endinterface

interface tksd_result_if import tksd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd_code;
  logic [BYTE_W-1:0] read_char;
  logic [LEN_W-1:0]  typed_len;

  modport source (output valid, output cmd_code, output read_char, output typed_len,
                  input ready);
  modport sink   (input valid, input cmd_code, input read_char, input typed_len,
                  output ready);
endinterface

// ----- design/terminal_key_sequence_decoder_core.sv -----
// channel  | dir | payload                          | beat
// ---------+-----+----------------------------------+----------------------------
// item     | in  | req_type, rx_byte, read_index    | valid && ready at clk rise
// result   | out | cmd_code, read_char, typed_len   | valid && ready at clk rise
//
// one beat in, one beat out; an item beat loads the decode stage register,
// and its result is then held in the result register
// a new item beat can be taken every cycle unless the result stalls: the
// stage register feeds the decode, state update and result register in one step
// rst (synchronous, active high) clears the parser, the length and both valids;
// the line buffer holds no reset and is only read below the current length
// a stalled result holds the decode stage, which in turn holds item.ready low
module terminal_key_sequence_decoder_core import tksd_pkg::*; (
  input  logic clk,
  input  logic rst,
  tksd_item_if.sink     item,
  tksd_result_if.source result
);

  // line buffer, one write and one read port
  logic [BYTE_W-1:0] line_buffer [LINE_MAX];

  // decode stage register
  logic              s1_valid;
  logic [REQ_W-1:0]  s1_req;
  logic [BYTE_W-1:0] s1_byte;
  logic [IDX_W-1:0]  s1_idx;
  logic [BYTE_W-1:0] s1_rdata;

  // architectural state
  parse_state_t parse_state, parse_state_next;
  logic [LEN_W-1:0] line_length, line_length_next;

  // result register
  logic              out_valid;
  logic [CMD_W-1:0]  out_cmd;
  logic [BYTE_W-1:0] out_char;
  logic [LEN_W-1:0]  out_len;

  // decode results
  logic [CMD_W-1:0]  cmd_next;
  logic [BYTE_W-1:0] char_next;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              go;
  logic              item_take;

  // decode stage moves when the result slot is free or being emptied
  assign go        = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || go;
  assign item_take = item.valid && item.ready;
  assign wr_addr   = line_length[ADDR_W-1:0];

  always_comb begin
    logic plain;
    logic typable;
    logic erase;
    logic [BYTE_W-1:0] b;

    b                = s1_byte;
    plain            = 1'b0;
    cmd_next         = ACT_NONE;
    char_next        = '0;
    wr_en            = 1'b0;
    parse_state_next = parse_state;
    line_length_next = line_length;

    typable = (b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122) ||
              (b >= 8'd48 && b <= 8'd57) || b == 8'd32 || b == K_BS || b == K_DEL;
    erase   = (b == K_BS) || (b == K_DEL);

    case (s1_req)
      REQ_BYTE: begin
        if (b == K_QUIT) begin
          // quit leaves parser and buffer alone
          cmd_next = ACT_EXIT;
        end else begin
          case (parse_state)
            PS_IDLE: begin
              if (b == K_ESC) begin
                parse_state_next = PS_ESC;
              end else begin
                plain = 1'b1;
              end
            end
            PS_ESC: begin
              if (b == K_BRACKET) begin
                parse_state_next = PS_BRACKET;
              end else begin
                parse_state_next = PS_IDLE;
                plain            = 1'b1;
              end
            end
            PS_BRACKET: begin
              parse_state_next = PS_IDLE;
              case (b)
                K_UP_A:    cmd_next = ACT_UP;
                K_DOWN_B:  cmd_next = ACT_DOWN;
                K_RIGHT_C: cmd_next = ACT_RIGHT;
                K_LEFT_D:  cmd_next = ACT_LEFT;
                K_ONE: begin
                  cmd_next         = ACT_CONFIRM;
                  parse_state_next = PS_TILDE;
                end
                K_TWO: begin
                  cmd_next         = ACT_SHIFT_LEFT;
                  parse_state_next = PS_TILDE;
                end
                K_FIVE: begin
                  cmd_next         = ACT_SHIFT_RIGHT;
                  parse_state_next = PS_TILDE;
                end
                default: plain = 1'b1;
              endcase
            end
            default: begin
              // trailing tilde is swallowed, anything else handled as idle
              parse_state_next = PS_IDLE;
              plain            = (b != K_TILDE);
            end
          endcase

          // idle byte handling; a stray esc falls through as a no-op
          if (plain) begin
            if (typable) begin
              if (erase) begin
                if (line_length != '0) begin
                  line_length_next = line_length - LEN_W'(1);
                end
              end else if (line_length < LEN_W'(LINE_MAX)) begin
                wr_en            = 1'b1;
                line_length_next = line_length + LEN_W'(1);
              end
            end else if (b == K_LF || b == K_CR) begin
              cmd_next = ACT_LINE;
            end
          end
        end
      end
      REQ_READ: begin
        if ({1'b0, s1_idx} < line_length) begin
          char_next = s1_rdata;
        end
      end
      REQ_CLEAR: begin
        line_length_next = '0;
      end
      default: begin
      end
    endcase
  end

  // buffer write and registered read, with forwarding of a same-cycle write
  always_ff @(posedge clk) begin
    if (go && wr_en) begin
      line_buffer[wr_addr] <= s1_byte;
    end
    if (item_take) begin
      if (go && wr_en && wr_addr == item.read_index) begin
        s1_rdata <= s1_byte;
      end else begin
        s1_rdata <= line_buffer[item.read_index];
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (item_take) begin
      s1_req  <= item.req_type;
      s1_byte <= item.rx_byte;
      s1_idx  <= item.read_index;
    end
  end

  // control, state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      parse_state <= PS_IDLE;
      line_length <= '0;
    end else begin
      if (item_take) begin
        s1_valid <= 1'b1;
      end else if (go) begin
        s1_valid <= 1'b0;
      end
      if (go) begin
        out_valid   <= 1'b1;
        parse_state <= parse_state_next;
        line_length <= line_length_next;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (go) begin
      out_cmd  <= cmd_next;
      out_char <= char_next;
      out_len  <= line_length_next;
    end
  end

  assign result.valid     = out_valid;
  assign result.cmd_code  = out_cmd;
  assign result.read_char = out_char;
  assign result.typed_len = out_len;

endmodule

// ----- design/tksd_checker.sv -----
`include "assert_macros.svh"

module tksd_checker import tksd_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_ready,
  input logic [CMD_W-1:0]  result_cmd_code,
  input logic [BYTE_W-1:0] result_read_char,
  input logic [LEN_W-1:0]  result_typed_len
);

  `ASSERT_CLK(a_rst_clears_result, clk, rst |=> !result_valid, "result valid after reset")

  `ASSERT_CLK_RST(a_stall_holds, clk, rst, result_valid && !result_ready |=> result_valid && $stable({result_cmd_code, result_read_char, result_typed_len}), "stalled result changed")

  `ASSERT_CLK_RST(a_char_only_on_read, clk, rst, result_valid && result_read_char != '0 |-> result_cmd_code == ACT_NONE && result_typed_len != '0, "read char with command or empty line")

  `ASSERT_CLK_RST(a_len_bounded, clk, rst, result_valid |-> result_typed_len <= LEN_W'(LINE_MAX) && result_cmd_code <= ACT_EXIT, "result field out of range")

endmodule

bind terminal_key_sequence_decoder_core tksd_checker u_tksd_checker (
  .clk              (clk),
  .rst              (rst),
  .result_valid     (result.valid),
  .result_ready     (result.ready),
  .result_cmd_code  (result.cmd_code),
  .result_read_char (result.read_char),
  .result_typed_len (result.typed_len)
);
